// ===== design/qpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, character codes and the hex digit lookup for the
// quoted-printable decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam logic [7:0] CHR_EQ = 8'h3D;
  localparam logic [7:0] CHR_US = 8'h5F;
  localparam logic [7:0] CHR_SP = 8'h20;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_CR = 8'h0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       error;
    logic       out_last;
  } out_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// ===== design/qpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_in_if / qpd_out_if
// Valid/ready stream channels carrying encoded bytes in and results out.
// ----------------------------------------------------------------------------
interface qpd_in_if import qpd_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qpd_out_if import qpd_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/qpd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_decode
// Input register plus escape state machine; produces one result per beat.
// ----------------------------------------------------------------------------
module qpd_decode import qpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic word_mode_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output out_t res_data_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_EQ, PH_HEX, PH_CR} phase_e;

  logic       s1_valid_q;
  in_t        s1_q;
  phase_e     phase_q, phase_d;
  logic [3:0] hi_q, hi_d;
  logic       err_q, err_d;
  logic       adv;
  logic [4:0] hv;
  logic       is_hex;
  logic [7:0] c;
  out_t       res;

  assign adv        = s1_valid_q && res_ready_i;
  assign in_ready_o = !s1_valid_q || res_ready_i;

  assign c      = s1_q.in_byte;
  assign hv     = hex_value(c);
  assign is_hex = !hv[4];

  always_comb begin
    res          = '0;
    res.out_last = s1_q.in_last;
    phase_d      = phase_q;
    hi_d         = hi_q;
    err_d        = err_q;
    if (!err_q) begin
      case (phase_q)
        PH_IDLE: begin
          if (c == CHR_EQ) begin
            phase_d = PH_EQ;
          end else if (word_mode_i && c == CHR_US) begin
            res.out_valid = 1'b1;
            res.out_byte  = CHR_SP;
          end else begin
            res.out_valid = 1'b1;
            res.out_byte  = c;
          end
        end
        PH_EQ: begin
          if (!word_mode_i && c == CHR_LF) begin
            phase_d = PH_IDLE;
          end else if (!word_mode_i && c == CHR_CR) begin
            phase_d = PH_CR;
          end else if (is_hex) begin
            hi_d    = hv[3:0];
            phase_d = PH_HEX;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_HEX: begin
          phase_d = PH_IDLE;
          if (is_hex) begin
            res.out_valid = 1'b1;
            res.out_byte  = {hi_q, hv[3:0]};
          end else begin
            err_d = 1'b1;
          end
        end
        PH_CR: begin
          phase_d = PH_IDLE;
          if (c != CHR_LF) begin
            err_d = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      if (s1_q.in_last && phase_d != PH_IDLE) begin
        err_d = 1'b1;
      end
      if (err_d) begin
        res.out_valid = 1'b0;
        res.out_byte  = '0;
        phase_d       = PH_IDLE;
      end
    end
    res.error = err_d;
    if (s1_q.in_last) begin
      phase_d = PH_IDLE;
      hi_d    = '0;
      err_d   = 1'b0;
    end
  end

  assign res_valid_o = s1_valid_q;
  assign res_data_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PH_IDLE;
      hi_q       <= '0;
      err_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        phase_q <= phase_d;
        hi_q    <= hi_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> phase_q == PH_IDLE)
    else $error("escape pending while in error");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_q.in_last |=> phase_q == PH_IDLE && !err_q && hi_q == 4'd0)
    else $error("state not cleared after last beat");

  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && res.out_valid |-> !res.error)
    else $error("decoded byte issued with error set");

  a_err_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && err_q |-> res.error && !res.out_valid)
    else $error("sticky error not reported");

endmodule

// ===== design/qpd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpd_out_reg
// Result register between the decoder and the output channel.
// ----------------------------------------------------------------------------
module qpd_out_reg import qpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  out_t res_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic full_q;
  out_t data_q;

  assign res_ready_o = !full_q || out_ready_i;
  assign out_valid_o = full_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (res_ready_o) begin
      full_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_data_i;
    end
  end

endmodule

// ===== design/quoted_printable_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_decoder_core
// Quoted-printable stream decoder, one encoded byte in, one result out.
//
//   channel   dir   payload                                 beat
//   in_if     in    in_byte, in_last                        valid & ready
//   out_if    out   out_valid, out_byte, error, out_last    valid & ready
//   cfg       in    word_mode                               cfg_we_i
//
// One beat per cycle sustained while out_if does not stall; a result passes
// the input register, then the result register, before it reaches out_if.
// Reset clears the pipeline, the escape state and word_mode.
// A stall on out_if holds the result register; input keeps flowing until
// the input register is also full.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_core import qpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  qpd_in_if.sink     in_if,
  qpd_out_if.source  out_if
);

  logic word_mode_q;
  logic res_valid;
  logic res_ready;
  out_t res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      word_mode_q <= cfg_wdata_i;
    end
  end

  qpd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_mode_i (word_mode_q),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_data_i   (in_if.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  qpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_data_i  (res_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

endmodule
